// ----- rtl/itrd_pkg.sv -----
// Shared constants and the digit glyph function for the integer to
// radix digits block. No dependencies; imported by every module of the block.
`default_nettype none

package itrd_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_DIGITS_DEF = 32;
   localparam int OUT_LIMIT      = 32;
   localparam int STEP_BITS      = 8;
   localparam int RADIX_W        = 5;
   localparam int DIGIT_W        = 4;
   localparam int CHAR_W         = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'h41;
   localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;

   // Map a digit value to its upper-case ASCII character.
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_DIGITS) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_ALPHA + {3'b000, d - DEC_DIGITS};
      end
      return c;
   endfunction

endpackage : itrd_pkg

`default_nettype wire

// ----- rtl/integer_to_radix_digits.sv -----
// Top level of the integer to radix digits block: sequencer, digit store and
// output stage. Depends on itrd_pkg and itrd_div_step.
`default_nettype none

// Converts an unsigned VALUE_BITS number into its digits in a radix of 2 to
// 16 (a radix below 2 is used as 2, above 16 as 16) and streams them out as
// upper-case ASCII characters, most significant first, with rsp_tlast on the
// final, least significant digit. A zero value gives the single item '0'.
// Digits are extracted least significant first by one shared divide unit
// that retires STEP_BITS dividend bits per cycle, and the division runs
// until the quotient reaches zero. Digits land in a small store and are
// read back in reverse order. Only the lowest min(MAX_DIGITS, 32) digits
// are kept; higher ones are dropped. req_tready is low from acceptance
// until the last digit has been taken.
module integer_to_radix_digits
   import itrd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // req_tdata, lowest bit up: value [VALUE_BITS-1:0], radix [VALUE_BITS+4:VALUE_BITS]
   input  wire logic [((VALUE_BITS+RADIX_W+7)/8)*8-1:0] req_tdata,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // rsp_tdata, lowest bit up: digit_char [6:0], zero fill [7]
   output logic [7:0]                                   rsp_tdata,
   output logic                                         rsp_tlast,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready
);

   localparam int CAP    = (MAX_DIGITS < OUT_LIMIT) ? MAX_DIGITS : OUT_LIMIT;
   localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int WORD   = CHUNKS * STEP_BITS;
   localparam int CNT_W  = $clog2(CAP + 1);
   localparam int IDX_W  = $clog2(CAP);
   localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_FETCH  = 4'b0100,
      ST_SEND   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [WORD-1:0]    quo_ff, quo_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [CH_W-1:0]    chunk_ff, chunk_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [DIGIT_W-1:0] rd_data_ff;

   logic [DIGIT_W-1:0] rem_step;
   logic [WORD-1:0]    quo_step;
   logic [RADIX_W-1:0] req_radix;
   logic [RADIX_W-1:0] radix_clamped;
   logic               wr_en;
   logic               chunk_last;

   // Digit store, least significant digit at index zero.
   logic [DIGIT_W-1:0] store_mem [CAP];

   assign req_radix = req_tdata[VALUE_BITS+RADIX_W-1:VALUE_BITS];

   // Clamp the radix into the supported range.
   always_comb begin
      priority if (req_radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_radix;
      end
   end

   itrd_div_step #(
      .WORD_BITS (WORD)
   ) u_div_step (
      .part_rem (rem_ff),
      .part_quo (quo_ff),
      .divisor  (radix_ff),
      .rem_step (rem_step),
      .quo_step (quo_step)
   );

   assign chunk_last = (chunk_ff == CH_W'(CHUNKS - 1));

   always_comb begin
      state_in  = state_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      radix_in  = radix_ff;
      chunk_in  = chunk_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // Load the item and start the first digit.
            if (req_tvalid) begin
               quo_in   = WORD'(req_tdata[VALUE_BITS-1:0]);
               rem_in   = '0;
               radix_in = radix_clamped;
               chunk_in = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quo_in = quo_step;
            rem_in = rem_step;
            if (chunk_last) begin
               // Remainder is a finished digit; keep it only while there is room.
               rem_in   = '0;
               chunk_in = '0;
               wr_en    = (cnt_ff < CNT_W'(CAP));
               if (wr_en) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (quo_step == '0) begin
                  rd_idx_in = IDX_W'(cnt_in - 1'b1);
                  state_in  = ST_FETCH;
               end
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            // Advance toward the least significant digit on each taken item.
            if (rsp_tready) begin
               if (rd_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         chunk_ff  <= '0;
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         chunk_ff  <= chunk_in;
         cnt_ff    <= cnt_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   // Store write and registered read; the read follows the next index so the
   // data register always matches rd_idx_ff while sending.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[cnt_ff[IDX_W-1:0]] <= rem_step;
      end
      rd_data_ff <= store_mem[rd_idx_in];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = {1'b0, glyph(rd_data_ff)};
   assign rsp_tlast  = (rd_idx_ff == '0);

`ifndef ASSERT_OFF
   a_send_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CNT_W'(rd_idx_ff) < cnt_ff))
      else $error("read index beyond stored digit count");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while digits are still pending");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not ready after final digit");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("digit stream broke off before final digit");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DIVIDE && cnt_ff == '0))
      else $error("accepted item did not start a fresh division");
`endif

endmodule : integer_to_radix_digits

`default_nettype wire

// ----- rtl/itrd_div_step.sv -----
// Shared divide unit: STEP_BITS restoring steps of a long division by a
// radix of at most sixteen. Depends on itrd_pkg.
`default_nettype none

module itrd_div_step
   import itrd_pkg::*;
#(
   parameter int WORD_BITS = VALUE_BITS_DEF
) (
   input  wire logic [DIGIT_W-1:0]   part_rem,
   input  wire logic [WORD_BITS-1:0] part_quo,
   input  wire logic [RADIX_W-1:0]   divisor,
   output logic      [DIGIT_W-1:0]   rem_step,
   output logic      [WORD_BITS-1:0] quo_step
);

   always_comb begin
      logic [RADIX_W-1:0]   r5;
      logic [WORD_BITS-1:0] q;
      logic [DIGIT_W-1:0]   r;
      r  = part_rem;
      q  = part_quo;
      r5 = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         // Bring down the next dividend bit; quotient bit shifts in below.
         r5 = {r, q[WORD_BITS-1]};
         q  = {q[WORD_BITS-2:0], 1'b0};
         if (r5 >= divisor) begin
            r5   = r5 - divisor;
            q[0] = 1'b1;
         end
         r = r5[DIGIT_W-1:0];
      end
      rem_step = r;
      quo_step = q;
   end

endmodule : itrd_div_step

`default_nettype wire
